>>> rtl/tdcc_pkg.sv
// ----------------------------------------------------------------------------
// tdcc_pkg
// Widths, reset values and calendar constants for the tick-driven calendar
// clock.
// ----------------------------------------------------------------------------
package tdcc_pkg;

  // Bus and field widths
  localparam int APB_DW   = 32;
  localparam int ADDR_W   = 2;
  localparam int TPS_W    = 20;
  localparam int TICK_W   = 32;
  localparam int OUT_W    = 40;
  localparam int MIN_W    = 6;
  localparam int HOUR_W   = 5;
  localparam int DAY_W    = 9;
  localparam int YEAR_W   = 16;
  localparam int DSE_W    = 16;
  localparam int MONTH_W  = 4;
  localparam int DOM_W    = 5;

  // Per-minute and per-hour tick counts at the largest rate
  localparam int PMIN_W   = 26;
  localparam int PHOUR_W  = 32;
  localparam int MT_W     = MIN_W + PMIN_W;
  localparam int HT_W     = HOUR_W + PHOUR_W;
  localparam int TS_W     = OUT_W + 2;

  localparam logic [TPS_W-1:0]   TPS_RESET      = 20'd1000000;
  localparam logic [PMIN_W-1:0]  PER_MIN_RESET  = 26'd60000000;
  localparam logic [PHOUR_W-1:0] PER_HOUR_RESET = 32'd3600000000;
  localparam logic [OUT_W-1:0]   OUT_MAX        = '1;

  localparam logic [MIN_W-1:0]  MIN_LAST   = 6'd59;
  localparam logic [HOUR_W-1:0] HOUR_LAST  = 5'd23;
  localparam logic [DAY_W-1:0]  DAY_LAST   = 9'd364;
  localparam logic [YEAR_W-1:0] YEAR_RESET = 16'd2020;

  // Days since epoch: low 16 bits of floor((year - 1970) * 1461 / 4)
  localparam int EP_W = DSE_W + 2;
  localparam logic [EP_W-1:0] EPOCH_YEAR = 18'd1970;
  localparam logic [EP_W-1:0] DAYS_4Y    = 18'd1461;

  // Divisibility by 25: multiply by the inverse of 25 mod 2^16 and compare
  localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

  // Month lookup
  localparam int NUM_MONTHS = 12;
  localparam int MON_IDX_W  = 4;
  localparam int MARCH      = 2;
  localparam int DN_W       = DAY_W + 1;
  localparam logic [DAY_W-1:0] MONTH_START [NUM_MONTHS] = '{
    9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

endpackage

>>> rtl/tick_driven_calendar_clock.sv
// ----------------------------------------------------------------------------
// tick_driven_calendar_clock
// Turns free-running tick counter samples into minute, hour, day, year,
// month and day-of-month fields, with ticks within the minute and the day.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | sink      | in_valid / in_stall     | tick_sample
//  out     | source    | out_valid / out_stall   | time and calendar fields
//  cfg     | APB slave | psel penable pwrite ... | ticks_per_second, any address
//
//  One beat per cycle sustained while the output is not stalled. The counter
//  state is updated at the accepting edge; products and the month lookup follow
//  in two register stages, stage 2 and the result register.
//  Reset (rst, synchronous) empties all stages and restores the calendar to
//  day 0 of 2020 and the rate to 1000000 ticks per second.
//  A stalled output holds its stages; the input stalls once all three are full.
//
module tick_driven_calendar_clock #(
  parameter int ACC_WIDTH = 40
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tdcc_pkg::ADDR_W-1:0]    paddr,
  input  logic [tdcc_pkg::APB_DW-1:0]    pwdata,
  output logic [tdcc_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tdcc_pkg::TICK_W-1:0]    tick_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tdcc_pkg::OUT_W-1:0]     sub_minute_ticks,
  output logic [tdcc_pkg::MIN_W-1:0]     minute_now,
  output logic [tdcc_pkg::HOUR_W-1:0]    hour_now,
  output logic [tdcc_pkg::DAY_W-1:0]     day_in_year,
  output logic [tdcc_pkg::YEAR_W-1:0]    year_now,
  output logic [tdcc_pkg::DSE_W-1:0]     days_since_epoch,
  output logic [tdcc_pkg::OUT_W-1:0]     ticks_in_day,
  output logic [tdcc_pkg::MONTH_W-1:0]   month_now,
  output logic [tdcc_pkg::DOM_W-1:0]     day_of_month
);
  import tdcc_pkg::*;

  localparam int XW = (ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W;
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = '1;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  logic [TPS_W-1:0]   tps;
  logic [PMIN_W-1:0]  per_min;
  logic [PHOUR_W-1:0] per_hour;
  logic [TPS_W-1:0]   tps_wr;
  logic [TPS_W-1:0]   rate_wr;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign prdata  = APB_DW'(tps);
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign tps_wr  = pwdata[TPS_W-1:0];
  // a zero rate counts as one tick per second
  assign rate_wr = (tps_wr == '0) ? TPS_W'(1) : tps_wr;

  // single register: every write lands on it
  always_ff @(posedge clk) begin
    if (rst) begin
      tps      <= TPS_RESET;
      per_min  <= PER_MIN_RESET;
      per_hour <= PER_HOUR_RESET;
    end else if (cfg_wr) begin
      tps      <= tps_wr;
      per_min  <= PMIN_W'(rate_wr) * PMIN_W'(60);
      per_hour <= PHOUR_W'(rate_wr) * PHOUR_W'(3600);
    end
  end

  // --------------------------------------------------------------------------
  // Stage control
  // --------------------------------------------------------------------------
  logic v1, v2;
  logic s1_load, s2_load, s3_load;

  assign s3_load  = ~out_valid | ~out_stall;
  assign s2_load  = ~v2 | s3_load;
  assign in_stall = v1 & ~s2_load;
  assign s1_load  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        v1 <= 1'b1;
      end else if (s2_load) begin
        v1 <= 1'b0;
      end
      if (s2_load) begin
        v2 <= v1;
      end
      if (s3_load) begin
        out_valid <= v2;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: clock state, updated by each input beat
  // --------------------------------------------------------------------------
  logic [TICK_W-1:0]    last_tick;
  logic [ACC_WIDTH-1:0] acc, acc_next;
  logic [MIN_W-1:0]     minute, minute_next;
  logic [HOUR_W-1:0]    hour, hour_next;
  logic [DAY_W-1:0]     day, day_next;
  logic [YEAR_W-1:0]    year, year_next;
  logic [TICK_W-1:0]    delta;
  logic [ACC_WIDTH:0]   sum;
  logic [ACC_WIDTH+1:0] diff;
  logic                 carry;

  assign delta = tick_sample - last_tick;
  assign sum   = {1'b0, acc} + (ACC_WIDTH+1)'(delta);
  assign diff  = {2'b00, acc} + (ACC_WIDTH+2)'(delta) - (ACC_WIDTH+2)'(per_min);

  always_comb begin
    // at most one minute carried per beat; a saturated sum always carries
    if (sum[ACC_WIDTH]) begin
      carry    = 1'b1;
      acc_next = ACC_MAX - ACC_WIDTH'(per_min);
    end else if (!diff[ACC_WIDTH+1]) begin
      carry    = 1'b1;
      acc_next = diff[ACC_WIDTH-1:0];
    end else begin
      carry    = 1'b0;
      acc_next = sum[ACC_WIDTH-1:0];
    end

    minute_next = minute;
    hour_next   = hour;
    day_next    = day;
    year_next   = year;
    if (carry) begin
      minute_next = minute + MIN_W'(1);
      if (minute >= MIN_LAST) begin
        minute_next = '0;
        hour_next   = hour + HOUR_W'(1);
        if (hour >= HOUR_LAST) begin
          hour_next = '0;
          day_next  = day + DAY_W'(1);
          if (day >= DAY_LAST) begin
            day_next  = '0;
            year_next = year + YEAR_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_tick <= '0;
      acc       <= '0;
      minute    <= '0;
      hour      <= '0;
      day       <= '0;
      year      <= YEAR_RESET;
    end else if (s1_load) begin
      last_tick <= tick_sample;
      acc       <= acc_next;
      minute    <= minute_next;
      hour      <= hour_next;
      day       <= day_next;
      year      <= year_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: products, epoch base and leap flag
  // --------------------------------------------------------------------------
  logic [XW-1:0]     acc_x;
  logic [OUT_W-1:0]  acc_sat;
  logic [EP_W-1:0]   epoch_prod;
  logic [YEAR_W-1:0] year_inv;
  logic              leap_c;

  logic [OUT_W-1:0]  s2_acc;
  logic [MT_W-1:0]   s2_min_ticks;
  logic [HT_W-1:0]   s2_hr_ticks;
  logic [MIN_W-1:0]  s2_minute;
  logic [HOUR_W-1:0] s2_hour;
  logic [DAY_W-1:0]  s2_day;
  logic [YEAR_W-1:0] s2_year;
  logic [DSE_W-1:0]  s2_epoch;
  logic              s2_leap;

  assign acc_x      = XW'(acc);
  assign acc_sat    = (acc_x > XW'(OUT_MAX)) ? OUT_MAX : acc_x[OUT_W-1:0];
  // modulo 2^18 is enough for the low 16 bits of the floored quarter
  assign epoch_prod = (EP_W'(year) - EPOCH_YEAR) * DAYS_4Y;
  assign year_inv   = year * INV25;
  // divisible by 100 means by 4 and by 25; by 400 means by 16 and by 25
  assign leap_c     = (year[1:0] == 2'b00) & ((year_inv > DIV25_MAX) | (year[3:0] == 4'h0));

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_acc       <= acc_sat;
      s2_min_ticks <= MT_W'(minute) * MT_W'(per_min);
      s2_hr_ticks  <= HT_W'(hour) * HT_W'(per_hour);
      s2_minute    <= minute;
      s2_hour      <= hour;
      s2_day       <= day;
      s2_year      <= year;
      s2_epoch     <= epoch_prod[EP_W-1:2];
      s2_leap      <= leap_c;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: day ticks, days since epoch, month lookup; result register
  // --------------------------------------------------------------------------
  logic [TS_W-1:0]      tid_sum;
  logic [OUT_W-1:0]     tid;
  logic [DN_W-1:0]      day_num;
  logic [DN_W-1:0]      first [NUM_MONTHS];
  logic [MON_IDX_W-1:0] mon_idx;

  assign tid_sum = TS_W'(s2_acc) + TS_W'(s2_min_ticks) + TS_W'(s2_hr_ticks);
  assign tid     = (tid_sum > TS_W'(OUT_MAX)) ? OUT_MAX : tid_sum[OUT_W-1:0];
  assign day_num = DN_W'(s2_day) + DN_W'(1);

  // month = count of month starts that the day number lies past
  always_comb begin
    mon_idx = '0;
    for (int k = 0; k < NUM_MONTHS; k++) begin
      first[k] = DN_W'(MONTH_START[k]) + DN_W'(s2_leap && (k >= MARCH));
      if (k > 0 && day_num > first[k]) begin
        mon_idx = MON_IDX_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      sub_minute_ticks <= s2_acc;
      minute_now       <= s2_minute;
      hour_now         <= s2_hour;
      day_in_year      <= s2_day;
      year_now         <= s2_year;
      days_since_epoch <= s2_epoch + DSE_W'(s2_day);
      ticks_in_day     <= tid;
      month_now        <= MONTH_W'(mon_idx) + MONTH_W'(1);
      day_of_month     <= DOM_W'(day_num - first[mon_idx]);
    end
  end

endmodule

>>> rtl/tdcc_checker.sv
// ----------------------------------------------------------------------------
// tdcc_checker
// Port-level checks for the tick-driven calendar clock, bound to the top.
// ----------------------------------------------------------------------------
module tdcc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [tdcc_pkg::APB_DW-1:0]    pwdata,
  input logic [tdcc_pkg::APB_DW-1:0]    prdata,
  input logic                           pready,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [tdcc_pkg::OUT_W-1:0]     sub_minute_ticks,
  input logic [tdcc_pkg::DSE_W-1:0]     days_since_epoch,
  input logic [tdcc_pkg::OUT_W-1:0]     ticks_in_day,
  input logic [tdcc_pkg::DOM_W-1:0]     day_of_month
);
  import tdcc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(ticks_in_day) &&
      $stable(sub_minute_ticks) && $stable(days_since_epoch) && $stable(day_of_month))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // with the result register empty the whole pipe drains, so input is free
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready |=>
      prdata == APB_DW'($past(pwdata[TPS_W-1:0])))
    else $error("rate register readback mismatch");

  a_day_ticks: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ticks_in_day >= sub_minute_ticks)
    else $error("ticks in day below ticks in minute");

endmodule

bind tick_driven_calendar_clock tdcc_checker u_tdcc_checker (.*);

>>> verif/tdcc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tdcc_monitor
// Watches the config, input and output channels of the calendar clock. Each
// accepted tick beat updates a private copy of the calendar and queues the
// fields it should produce. Each result beat is compared against the oldest
// queued entry, field by field.
// ----------------------------------------------------------------------------
module tdcc_monitor
  import tdcc_pkg::*;
#(
  parameter logic [ADDR_W-1:0] TPS_ADDR = '0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic                 pready,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [TICK_W-1:0]    tick_sample,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [OUT_W-1:0]     sub_minute_ticks,
  input  logic [MIN_W-1:0]     minute_now,
  input  logic [HOUR_W-1:0]    hour_now,
  input  logic [DAY_W-1:0]     day_in_year,
  input  logic [YEAR_W-1:0]    year_now,
  input  logic [DSE_W-1:0]     days_since_epoch,
  input  logic [OUT_W-1:0]     ticks_in_day,
  input  logic [MONTH_W-1:0]   month_now,
  input  logic [DOM_W-1:0]     day_of_month,
  output int                   mismatches,
  output int                   pending
);

  localparam int EPOCH       = 1970;
  localparam int DAYS_PER_4Y = 1461;
  localparam int LAST_MONTH  = 11;
  localparam int FEB         = 1;

  typedef struct packed {
    logic [OUT_W-1:0]   sub_min;
    logic [MIN_W-1:0]   minute;
    logic [HOUR_W-1:0]  hour;
    logic [DAY_W-1:0]   day;
    logic [YEAR_W-1:0]  year;
    logic [DSE_W-1:0]   dse;
    logic [OUT_W-1:0]   tid;
    logic [MONTH_W-1:0] month;
    logic [DOM_W-1:0]   dom;
  } cal_fields_t;

  cal_fields_t expected_cal [$];

  logic [TPS_W-1:0]  rate_cfg;
  logic [TICK_W-1:0] prev_tick;
  logic [OUT_W-1:0]  acc;
  logic [MIN_W-1:0]  minute_r;
  logic [HOUR_W-1:0] hour_r;
  logic [DAY_W-1:0]  day_r;
  logic [YEAR_W-1:0] year_r;

  function automatic int month_length(input int m, input bit leap);
    case (m)
      FEB:           return leap ? 29 : 28;
      3, 5, 8, 10:   return 30;
      default:       return 31;
    endcase
  endfunction

  // Take one tick sample into the calendar and report the state after it.
  task automatic advance_calendar(input logic [TICK_W-1:0] t, output cal_fields_t r);
    logic [TICK_W-1:0] delta;
    logic [OUT_W:0]    sum;
    longint unsigned   per_min;
    longint unsigned   tid;
    int                yr_off;
    int                prod;
    int                dleft;
    int                m;
    bit                leap;
    delta   = t - prev_tick;
    per_min = (rate_cfg == '0 ? 64'd1 : 64'(rate_cfg)) * 64'd60;
    sum     = {1'b0, acc} + (OUT_W + 1)'(delta);
    acc     = sum[OUT_W] ? OUT_MAX : sum[OUT_W-1:0];
    // at most one minute per beat, the rest stays as backlog
    if (64'(acc) >= per_min) begin
      acc = acc - OUT_W'(per_min);
      if (minute_r == MIN_LAST) begin
        minute_r = '0;
        if (hour_r == HOUR_LAST) begin
          hour_r = '0;
          if (day_r == DAY_LAST) begin
            day_r  = '0;
            year_r = year_r + YEAR_W'(1);
          end else begin
            day_r = day_r + DAY_W'(1);
          end
        end else begin
          hour_r = hour_r + HOUR_W'(1);
        end
      end else begin
        minute_r = minute_r + MIN_W'(1);
      end
    end
    prev_tick = t;

    yr_off = int'(year_r) - EPOCH;
    prod   = yr_off * DAYS_PER_4Y;
    r.dse  = DSE_W'((prod >>> 2) + int'(day_r));

    tid = 64'(acc) + 64'(minute_r) * per_min + 64'(hour_r) * per_min * 64'd60;
    if (tid > 64'(OUT_MAX)) tid = 64'(OUT_MAX);
    r.tid = OUT_W'(tid);

    leap  = (year_r % 4 == 0) && ((year_r % 100 != 0) || (year_r % 400 == 0));
    dleft = int'(day_r) + 1;
    m     = 0;
    while (m < LAST_MONTH && dleft > month_length(m, leap)) begin
      dleft = dleft - month_length(m, leap);
      m++;
    end
    r.month   = MONTH_W'(m + 1);
    r.dom     = DOM_W'(dleft);
    r.sub_min = acc;
    r.minute  = minute_r;
    r.hour    = hour_r;
    r.day     = day_r;
    r.year    = year_r;
  endtask

  task automatic check_field(input string name, input longint unsigned exp_v,
                             input longint unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    cal_fields_t r;
    cal_fields_t e;
    if (rst) begin
      rate_cfg   = TPS_RESET;
      prev_tick  = '0;
      acc        = '0;
      minute_r   = '0;
      hour_r     = '0;
      day_r      = '0;
      year_r     = YEAR_RESET;
      mismatches = 0;
      expected_cal.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == TPS_ADDR)
        rate_cfg = pwdata[TPS_W-1:0];
      if (in_valid && !in_stall) begin
        advance_calendar(tick_sample, r);
        expected_cal.push_back(r);
      end
      if (out_valid && !out_stall) begin
        if (expected_cal.size() == 0) begin
          mismatches++;
          $error("result beat with nothing expected");
        end else begin
          e = expected_cal.pop_front();
          check_field("sub_minute_ticks", e.sub_min, sub_minute_ticks);
          check_field("minute_now", e.minute, minute_now);
          check_field("hour_now", e.hour, hour_now);
          check_field("day_in_year", e.day, day_in_year);
          check_field("year_now", e.year, year_now);
          check_field("days_since_epoch", e.dse, days_since_epoch);
          check_field("ticks_in_day", e.tid, ticks_in_day);
          check_field("month_now", e.month, month_now);
          check_field("day_of_month", e.dom, day_of_month);
        end
      end
    end
    pending = expected_cal.size();
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the tick-driven calendar clock. Drives tick samples and rate
// writes with random gaps and output stalls, and leaves prediction and
// comparison to the monitor beside the block.
// ----------------------------------------------------------------------------
module tb;
  import tdcc_pkg::*;

  localparam logic [ADDR_W-1:0] TPS_ADDR = '0;
  localparam logic [TPS_W-1:0]  TPS_MAX  = '1;
  localparam logic [TPS_W-1:0]  TPS_TOP  = 20'd1000000;
  localparam int LIMIT       = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_MAX    = 16;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_stall;
  logic [TICK_W-1:0]   tick_sample;
  logic                out_valid;
  logic                out_stall;
  logic [OUT_W-1:0]    sub_minute_ticks;
  logic [MIN_W-1:0]    minute_now;
  logic [HOUR_W-1:0]   hour_now;
  logic [DAY_W-1:0]    day_in_year;
  logic [YEAR_W-1:0]   year_now;
  logic [DSE_W-1:0]    days_since_epoch;
  logic [OUT_W-1:0]    ticks_in_day;
  logic [MONTH_W-1:0]  month_now;
  logic [DOM_W-1:0]    day_of_month;

  int          mismatches;
  int          pending;
  int          cycles = 0;
  int          gap_max;
  int          stall_max;
  int          holds_requested;
  logic [TICK_W-1:0] cur_tick;

  tick_driven_calendar_clock dut (.*);

  tdcc_monitor #(.TPS_ADDR(TPS_ADDR)) u_monitor (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Output side: stall each result beat for a random count, plus long holds on request.
  initial begin
    int holds_done;
    int k;
    holds_done = 0;
    out_stall  = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (holds_done != holds_requested) begin
        holds_done++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        k = (stall_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, stall_max);
        if (k > 0) begin
          out_stall <= 1'b1;
          repeat (k) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Entered and left at a falling edge.
  task automatic send_beat(input logic [TICK_W-1:0] t);
    int gap;
    gap = (gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    tick_sample <= t;
    cur_tick     = t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [APB_DW-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop sending and wait out every queued result plus the pipeline.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_rate(input logic [TPS_W-1:0] tps);
    drain();
    apb_write(TPS_ADDR, APB_DW'(tps));
  endtask

  initial begin
    logic [TICK_W-1:0] dir_ticks [12];
    int i;
    int sel;
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid        = 1'b0;
    tick_sample     = '0;
    gap_max         = IDLE_MAX;
    stall_max       = IDLE_MAX;
    holds_requested = 0;
    cur_tick        = '0;
    dir_ticks = '{32'd0, 32'd59999999, 32'd60000000, 32'hFFFFFFFF, 32'd0, 32'd0,
                  32'd0, 32'h7FFFFFFF, 32'h7FFFFFFE, 32'h7FFFFFFE, 32'h80000000,
                  32'hFFFFFFFF};
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: exact minute boundary, wrap, huge deltas and backlog at reset rate
    apb_write(TPS_ADDR, APB_DW'(TPS_TOP));
    foreach (dir_ticks[j]) send_beat(dir_ticks[j]);
    set_rate('0);
    send_beat(cur_tick + 32'd59);
    send_beat(cur_tick + 32'd1);
    send_beat(cur_tick);
    set_rate(TPS_MAX);
    send_beat(cur_tick - 32'd1);
    send_beat(cur_tick + 32'd62914500);
    send_beat(cur_tick);
    set_rate(20'd1);
    send_beat(32'h55555555);
    send_beat(32'hAAAAAAAA);
    send_beat(cur_tick);

    // drive the accumulator into saturation with maximal deltas
    set_rate(TPS_MAX);
    for (i = 0; i < 300; i++) begin
      if ($urandom_range(0, 9) == 0) send_beat($urandom);
      else send_beat(cur_tick - 32'd1);
    end

    // zero rate: saturated backlog carries a minute per beat; one long output hold
    set_rate('0);
    for (i = 0; i < 600; i++) begin
      if (i == 100) holds_requested++;
      gap_max = (i >= 100 && i < 140) ? 0 : IDLE_MAX;
      sel = $urandom_range(0, 9);
      if (sel < 7) send_beat(cur_tick + 32'($urandom_range(0, 200)));
      else if (sel < 9) send_beat($urandom);
      else send_beat(cur_tick);
    end
    gap_max = IDLE_MAX;

    // rate one: run on toward the end of the day, with a stretch of no idling
    set_rate(20'd1);
    for (i = 0; i < 500; i++) begin
      gap_max   = (i >= 200 && i < 350) ? 0 : IDLE_MAX;
      stall_max = gap_max;
      sel = $urandom_range(0, 9);
      if (sel < 6) send_beat(cur_tick + 32'($urandom_range(0, 100)));
      else send_beat($urandom);
    end
    gap_max   = IDLE_MAX;
    stall_max = IDLE_MAX;

    // assorted rates with random samples
    for (sel = 0; sel < 4; sel++) begin
      set_rate(sel == 0 ? TPS_TOP : 20'($urandom_range(1, 32'(TPS_MAX))));
      for (i = 0; i < 25; i++) begin
        if ($urandom_range(0, 1) == 0) send_beat($urandom);
        else send_beat(cur_tick + $urandom_range(0, 32'd200000000));
      end
    end

    drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
